FILE: hdl/rsi_pkg.sv
// ============================================================================
// rsi_pkg: shared types and constants for the ray-sphere intersection core
// Holds the transaction structs, the internal datapath widths and the
// pipeline latency used by the core and its multiplier.
// ============================================================================
`default_nettype none

package rsi_pkg;

    // Field widths of the transactions.
    localparam int COORD_W = 32;
    localparam int RAD_W   = COORD_W - 1;
    localparam int FRAC_W  = 16;
    localparam int OUT_W   = 32;

    // Multiplier digit size and latency.
    localparam int DIG_W   = 32;
    localparam int MUL_LAT = 3;

    // Internal widths, all exact for the coordinate width above.
    localparam int DL_W   = COORD_W + 1;        // delta = origin - center, signed
    localparam int A_W    = 2 * COORD_W + 1;    // A = dir.dir, unsigned
    localparam int B_W    = 2 * COORD_W + 3;    // B = 2 dir.delta, signed
    localparam int C_W    = 2 * COORD_W + 3;    // C = delta.delta - r^2, signed
    localparam int BM_W   = 2 * COORD_W + 2;    // |B|
    localparam int CM_W   = 2 * COORD_W + 2;    // |C|
    localparam int SQ_W   = 2 * COORD_W + 3;    // square root of D
    localparam int D_W    = 2 * SQ_W;           // D, signed
    localparam int T_W    = D_W + 1;            // square root trial value
    localparam int NUM_W  = 2 * COORD_W + 5;    // -B -/+ S, signed
    localparam int NM_W   = NUM_W + FRAC_W;     // scaled numerator magnitude
    localparam int DEN_W  = A_W + 1;            // 2A
    localparam int Q_W    = OUT_W + 1;          // quotient bits kept
    localparam int X_W    = DEN_W + Q_W + 1;    // divider remainder width

    // Cycles from an accepted input to its result in the output register.
    localparam int LAT = 12 + SQ_W + Q_W;

    // Root count codes.
    localparam logic [1:0] ROOTS_NONE = 2'd0;
    localparam logic [1:0] ROOTS_ONE  = 2'd1;
    localparam logic [1:0] ROOTS_TWO  = 2'd2;

    // Clip values of a root.
    localparam logic [OUT_W-1:0] T_MAX = {1'b0, {(OUT_W - 1){1'b1}}};
    localparam logic [OUT_W-1:0] T_MIN = {1'b1, {(OUT_W - 1){1'b0}}};

    typedef struct packed {
        logic signed [COORD_W-1:0] origin_x;
        logic signed [COORD_W-1:0] origin_y;
        logic signed [COORD_W-1:0] origin_z;
        logic signed [COORD_W-1:0] dir_x;
        logic signed [COORD_W-1:0] dir_y;
        logic signed [COORD_W-1:0] dir_z;
        logic signed [COORD_W-1:0] center_x;
        logic signed [COORD_W-1:0] center_y;
        logic signed [COORD_W-1:0] center_z;
        logic        [RAD_W-1:0]   sphere_radius;
    } t_ray_in;

    typedef struct packed {
        logic        [1:0]       root_count;
        logic signed [OUT_W-1:0] t_near;
        logic signed [OUT_W-1:0] t_far;
        logic                    saturated;
    } t_ray_out;

    // Status that rides along with the data.
    typedef struct packed {
        logic a_zero;
        logic d_neg;
        logic d_zero;
    } t_flags;

    // Side data through the square root stages.
    typedef struct packed {
        logic [B_W-1:0] b;
        logic [A_W-1:0] a;
        t_flags         flg;
    } t_sq_side;

    // Side data through the divider stages.
    typedef struct packed {
        logic [DEN_W-1:0] den;
        t_flags           flg;
    } t_dv_side;

endpackage

`default_nettype wire

FILE: hdl/rsi_mul.sv
// ============================================================================
// rsi_mul: pipelined unsigned multiplier
// Splits both operands into digits, forms the digit products, sums them by
// rows and then sums the rows, one register stage each.
// ============================================================================
`default_nettype none

module rsi_mul
    import rsi_pkg::*;
#(
    parameter int AW = 32,
    parameter int BW = 32
)
(
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [AW-1:0]  i_a,
    input  logic [BW-1:0]  i_b,
    output logic [AW+BW-1:0] o_p
);

    localparam int NA = (AW + DIG_W - 1) / DIG_W;
    localparam int NB = (BW + DIG_W - 1) / DIG_W;
    localparam int PW = AW + BW;

    logic [NA*DIG_W-1:0] a_ext;
    logic [NB*DIG_W-1:0] b_ext;
    logic [2*DIG_W-1:0]  r_pp  [NA][NB];
    logic [PW-1:0]       n_row [NA];
    logic [PW-1:0]       r_row [NA];
    logic [PW-1:0]       n_p;
    logic [PW-1:0]       r_p;

    assign a_ext = (NA*DIG_W)'(i_a);
    assign b_ext = (NB*DIG_W)'(i_b);

    // Stage one: digit products.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < NA; i++) begin
                for (int j = 0; j < NB; j++) begin
                    r_pp[i][j] <= a_ext[i*DIG_W +: DIG_W] * b_ext[j*DIG_W +: DIG_W];
                end
            end
        end
    end

    // Stage two: one row per digit of the first operand.
    always_comb begin
        for (int i = 0; i < NA; i++) begin
            n_row[i] = '0;
            for (int j = 0; j < NB; j++) begin
                n_row[i] = n_row[i] + (PW'(r_pp[i][j]) << (j * DIG_W));
            end
        end
    end

    // Stage three: sum of the rows.
    always_comb begin
        n_p = '0;
        for (int i = 0; i < NA; i++) begin
            n_p = n_p + (r_row[i] << (i * DIG_W));
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_row <= n_row;
            r_p   <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

`default_nettype wire

FILE: hdl/ray_sphere_intersection_core.sv
// ============================================================================
// ray_sphere_intersection_core: ray-sphere test by the quadratic formula
// Forms A, B, C and the discriminant exactly, takes its integer square root
// and divides both roots by 2A with floor rounding and clipping to Q16.16.
// ============================================================================
//
//   Channel   Direction  Handshake          Payload
//   input     in         i_valid / o_stall  i_data  (t_ray_in)
//   output    out        o_valid / i_stall  o_data  (t_ray_out)
//
// One transaction enters per cycle unless the output is stalled; each result
// leaves from the output register after all stages. The depth is set by the
// square root, one result bit per stage, and the dividers, one quotient bit
// per stage. A stalled output freezes the whole pipeline; o_stall is high
// only while a finished result is held. Reset clears the valid bits only.
//
`default_nettype none

module ray_sphere_intersection_core
    import rsi_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    output logic     o_stall,
    input  t_ray_in  i_data,
    output logic     o_valid,
    input  logic     i_stall,
    output t_ray_out o_data
);

    localparam int W = COORD_W;

    // Pipeline control.
    logic           adv;
    logic [LAT-1:0] r_vld;

    assign adv     = !(r_vld[LAT-1] && i_stall);
    assign o_stall = !adv;
    assign o_valid = r_vld[LAT-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[LAT-2:0], i_valid};
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: deltas and sign-magnitude operands.
    // ------------------------------------------------------------------
    logic [W-1:0]    v_in [3];
    logic [W-1:0]    o_in [3];
    logic [W-1:0]    c_in [3];
    logic [DL_W-1:0] dl   [3];
    logic [W-1:0]    r_vm [3];
    logic [DL_W-1:0] r_dm [3];
    logic [2:0]      r_vs;
    logic [2:0]      r_ds;
    logic [RAD_W-1:0] r_rad;

    assign v_in[0] = i_data.dir_x;
    assign v_in[1] = i_data.dir_y;
    assign v_in[2] = i_data.dir_z;
    assign o_in[0] = i_data.origin_x;
    assign o_in[1] = i_data.origin_y;
    assign o_in[2] = i_data.origin_z;
    assign c_in[0] = i_data.center_x;
    assign c_in[1] = i_data.center_y;
    assign c_in[2] = i_data.center_z;

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            dl[k] = {o_in[k][W-1], o_in[k]} - {c_in[k][W-1], c_in[k]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int k = 0; k < 3; k++) begin
                r_vm[k] <= v_in[k][W-1] ? (~v_in[k] + 1'b1) : v_in[k];
                r_dm[k] <= dl[k][DL_W-1] ? (~dl[k] + 1'b1) : dl[k];
                r_vs[k] <= v_in[k][W-1];
                r_ds[k] <= dl[k][DL_W-1];
            end
            r_rad <= i_data.sphere_radius;
        end
    end

    // ------------------------------------------------------------------
    // Stages 2 to 4: products for the dot products and r^2.
    // ------------------------------------------------------------------
    logic [2*W-1:0]      vv [3];
    logic [2*W:0]        vd [3];
    logic [2*DL_W-1:0]   dd [3];
    logic [2*RAD_W-1:0]  rr;
    logic [2:0]          r_vds_d [MUL_LAT];

    for (genvar k = 0; k < 3; k++) begin : g_dot
        rsi_mul #(.AW(W), .BW(W)) u_vv (
            .i_clk(i_clk), .i_en(adv), .i_a(r_vm[k]), .i_b(r_vm[k]), .o_p(vv[k])
        );
        rsi_mul #(.AW(W), .BW(DL_W)) u_vd (
            .i_clk(i_clk), .i_en(adv), .i_a(r_vm[k]), .i_b(r_dm[k]), .o_p(vd[k])
        );
        rsi_mul #(.AW(DL_W), .BW(DL_W)) u_dd (
            .i_clk(i_clk), .i_en(adv), .i_a(r_dm[k]), .i_b(r_dm[k]), .o_p(dd[k])
        );
    end

    rsi_mul #(.AW(RAD_W), .BW(RAD_W)) u_rr (
        .i_clk(i_clk), .i_en(adv), .i_a(r_rad), .i_b(r_rad), .o_p(rr)
    );

    // Signs of the dir*delta products follow the multipliers.
    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_vds_d[0] <= r_vs ^ r_ds;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_vds_d[i] <= r_vds_d[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: A, B and C.
    // ------------------------------------------------------------------
    logic [A_W-1:0] n_a;
    logic [B_W-2:0] n_bdot;
    logic [C_W-1:0] n_c;
    logic [A_W-1:0] r_a;
    logic [B_W-1:0] r_b;
    logic [C_W-1:0] r_c;

    always_comb begin
        n_a    = '0;
        n_bdot = '0;
        n_c    = '0;
        for (int k = 0; k < 3; k++) begin
            n_a    = n_a + A_W'(vv[k]);
            n_bdot = r_vds_d[MUL_LAT-1][k] ? n_bdot - (B_W-1)'(vd[k])
                                           : n_bdot + (B_W-1)'(vd[k]);
            n_c    = n_c + C_W'(dd[k]);
        end
        n_c = n_c - C_W'(rr);
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a <= n_a;
            r_b <= {n_bdot, 1'b0};
            r_c <= n_c;
        end
    end

    // ------------------------------------------------------------------
    // Stage 6: magnitudes of B and C.
    // ------------------------------------------------------------------
    logic [BM_W-1:0] r_bm;
    logic [CM_W-1:0] r_cm;
    logic            r_cs;
    logic [A_W-1:0]  r_a6;
    logic [B_W-1:0]  r_b6;

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_bm <= r_b[B_W-1] ? BM_W'(~r_b + 1'b1) : BM_W'(r_b);
            r_cm <= r_c[C_W-1] ? CM_W'(~r_c + 1'b1) : CM_W'(r_c);
            r_cs <= r_c[C_W-1];
            r_a6 <= r_a;
            r_b6 <= r_b;
        end
    end

    // ------------------------------------------------------------------
    // Stages 7 to 9: B^2 and A*|C|.
    // ------------------------------------------------------------------
    logic [2*BM_W-1:0]    bb;
    logic [A_W+CM_W-1:0]  ac;
    logic [A_W-1:0]       r_a_d  [MUL_LAT];
    logic [B_W-1:0]       r_b_d  [MUL_LAT];
    logic                 r_cs_d [MUL_LAT];

    rsi_mul #(.AW(BM_W), .BW(BM_W)) u_bb (
        .i_clk(i_clk), .i_en(adv), .i_a(r_bm), .i_b(r_bm), .o_p(bb)
    );
    rsi_mul #(.AW(A_W), .BW(CM_W)) u_ac (
        .i_clk(i_clk), .i_en(adv), .i_a(r_a6), .i_b(r_cm), .o_p(ac)
    );

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_a_d[0]  <= r_a6;
            r_b_d[0]  <= r_b6;
            r_cs_d[0] <= r_cs;
            for (int i = 1; i < MUL_LAT; i++) begin
                r_a_d[i]  <= r_a_d[i-1];
                r_b_d[i]  <= r_b_d[i-1];
                r_cs_d[i] <= r_cs_d[i-1];
            end
        end
    end

    // ------------------------------------------------------------------
    // Stage 10: discriminant D = B^2 - 4AC.
    // ------------------------------------------------------------------
    logic [A_W+CM_W+1:0] t4;
    logic [D_W-1:0]      n_d;
    logic [D_W-1:0]      r_sq_rem  [SQ_W+1];
    logic [SQ_W-1:0]     r_sq_root [SQ_W+1];
    t_sq_side            r_sq_side [SQ_W+1];

    assign t4 = {ac, 2'b00};

    always_comb begin
        n_d = D_W'(bb) + (r_cs_d[MUL_LAT-1] ? D_W'(t4) : (~D_W'(t4) + 1'b1));
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_sq_rem[0]             <= n_d[D_W-1] ? '0 : n_d;
            r_sq_root[0]            <= '0;
            r_sq_side[0].b          <= r_b_d[MUL_LAT-1];
            r_sq_side[0].a          <= r_a_d[MUL_LAT-1];
            r_sq_side[0].flg.a_zero <= (r_a_d[MUL_LAT-1] == '0);
            r_sq_side[0].flg.d_neg  <= n_d[D_W-1];
            r_sq_side[0].flg.d_zero <= (n_d == '0);
        end
    end

    // ------------------------------------------------------------------
    // Square root: one result bit per stage, most significant first.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < SQ_W; g++) begin : g_sqrt
        localparam int BI = SQ_W - 1 - g;
        logic [T_W-1:0] trial;
        logic           take;

        always_comb begin
            trial = (T_W'(r_sq_root[g]) << (BI + 1)) | (T_W'(1) << (2 * BI));
            take  = T_W'(r_sq_rem[g]) >= trial;
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_sq_rem[g+1]  <= take ? (r_sq_rem[g] - D_W'(trial)) : r_sq_rem[g];
                r_sq_root[g+1] <= r_sq_root[g] | (SQ_W'(take) << BI);
                r_sq_side[g+1] <= r_sq_side[g];
            end
        end
    end

    // ------------------------------------------------------------------
    // Numerators -B -/+ S, scaled by 2^16, as sign and magnitude.
    // ------------------------------------------------------------------
    t_sq_side         sq_out;
    logic [NUM_W-1:0] nb;
    logic [NUM_W-1:0] sx;
    logic [NUM_W-1:0] num  [2];
    logic [NUM_W-1:0] nmag [2];
    logic [X_W-1:0]   r_dv_rem [2][Q_W+1];
    logic [Q_W-1:0]   r_dv_q   [2][Q_W+1];
    logic             r_dv_neg [2][Q_W+1];
    logic             r_dv_hi  [2][Q_W+1];
    t_dv_side         r_dv_side [Q_W+1];

    assign sq_out = r_sq_side[SQ_W];

    always_comb begin
        nb     = ~{{(NUM_W - B_W){sq_out.b[B_W-1]}}, sq_out.b} + 1'b1;
        sx     = {{(NUM_W - SQ_W){1'b0}}, r_sq_root[SQ_W]};
        num[0] = nb - sx;
        num[1] = nb + sx;
        for (int l = 0; l < 2; l++) begin
            nmag[l] = num[l][NUM_W-1] ? (~num[l] + 1'b1) : num[l];
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            for (int l = 0; l < 2; l++) begin
                r_dv_rem[l][0] <= X_W'({nmag[l], {FRAC_W{1'b0}}});
                r_dv_q[l][0]   <= '0;
                r_dv_neg[l][0] <= num[l][NUM_W-1];
                r_dv_hi[l][0]  <= 1'b0;
            end
            r_dv_side[0].den <= {sq_out.a, 1'b0};
            r_dv_side[0].flg <= sq_out.flg;
        end
    end

    // ------------------------------------------------------------------
    // Dividers, two lanes: one quotient bit per stage. The first stage
    // also flags a quotient too large for the kept bits.
    // ------------------------------------------------------------------
    for (genvar g = 0; g < Q_W; g++) begin : g_div
        localparam int BI = Q_W - 1 - g;
        logic [X_W-1:0] dsh;
        logic [X_W-1:0] dtop;
        logic           take [2];
        logic           hi_now [2];

        always_comb begin
            dsh  = X_W'(r_dv_side[g].den) << BI;
            dtop = X_W'(r_dv_side[g].den) << Q_W;
            for (int l = 0; l < 2; l++) begin
                take[l]   = r_dv_rem[l][g] >= dsh;
                hi_now[l] = r_dv_rem[l][g] >= dtop;
            end
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                for (int l = 0; l < 2; l++) begin
                    r_dv_rem[l][g+1] <= take[l] ? (r_dv_rem[l][g] - dsh) : r_dv_rem[l][g];
                    r_dv_q[l][g+1]   <= r_dv_q[l][g] | (Q_W'(take[l]) << BI);
                    r_dv_neg[l][g+1] <= r_dv_neg[l][g];
                    r_dv_hi[l][g+1]  <= (g == 0) ? hi_now[l] : r_dv_hi[l][g];
                end
                r_dv_side[g+1] <= r_dv_side[g];
            end
        end
    end

    // ------------------------------------------------------------------
    // Final stage: floor rounding, clipping and root selection.
    // ------------------------------------------------------------------
    logic [Q_W:0]     qc  [2];
    logic [OUT_W-1:0] val [2];
    logic             sat [2];
    t_flags           fin;
    t_ray_out         n_out;
    t_ray_out         r_out;

    assign fin = r_dv_side[Q_W].flg;

    always_comb begin
        for (int l = 0; l < 2; l++) begin
            qc[l] = {1'b0, r_dv_q[l][Q_W]}
                  + (Q_W+1)'(r_dv_neg[l][Q_W] && (r_dv_rem[l][Q_W] != '0));
            if (!r_dv_neg[l][Q_W]) begin
                sat[l] = r_dv_hi[l][Q_W] || (r_dv_q[l][Q_W][Q_W-1:OUT_W-1] != '0);
                val[l] = sat[l] ? T_MAX : r_dv_q[l][Q_W][OUT_W-1:0];
            end else begin
                sat[l] = r_dv_hi[l][Q_W] || (qc[l] > ((Q_W+1)'(1) << (OUT_W - 1)));
                val[l] = sat[l] ? T_MIN : (~qc[l][OUT_W-1:0] + 1'b1);
            end
        end

        n_out = '0;
        if (!fin.a_zero && !fin.d_neg) begin
            n_out.t_near = val[0];
            if (fin.d_zero) begin
                n_out.root_count = ROOTS_ONE;
                n_out.saturated  = sat[0];
            end else begin
                n_out.root_count = ROOTS_TWO;
                n_out.t_far      = val[1];
                n_out.saturated  = sat[0] || sat[1];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out <= n_out;
        end
    end

    assign o_data = r_out;

    // ------------------------------------------------------------------
    // Assertions.
    // ------------------------------------------------------------------
    a_none_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.root_count == ROOTS_NONE) |->
            (o_data.t_near == '0) && (o_data.t_far == '0) && !o_data.saturated)
        else $error("zero-root result carries nonzero fields");

    a_one_far_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.root_count == ROOTS_ONE) |-> (o_data.t_far == '0))
        else $error("single-root result carries a far root");

    a_two_ordered: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_data.root_count == ROOTS_TWO) |-> (o_data.t_near <= o_data.t_far))
        else $error("near root lies beyond far root");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(r_vld))
        else $error("pipeline moved while output was stalled");

endmodule

`default_nettype wire
